// ===== rtl/bfa_pkg.sv =====
// Package: types, constants and helpers for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int unsigned FRAMES  = 4096;
  localparam int unsigned FRAME_W = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned WORDS   = FRAMES / WORD_W;
  localparam int unsigned WORD_AW = $clog2(WORDS);

  localparam logic [CNT_W-1:0] FRAMES_CNT = CNT_W'(FRAMES);

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_MARK  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_SAME    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [FRAME_W-1:0] frame;
  } bfa_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] granted_frame;
    logic [1:0]         status;
    logic [CNT_W-1:0]   free_cnt;
  } bfa_rsp_t;

  // index of lowest set bit (v must be nonzero for a meaningful result)
  function automatic logic [BIT_W-1:0] first_one(logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x;
    logic [BIT_W-1:0]  idx;
    x   = v;
    idx = '0;
    if (x[15:0] == '0) begin
      idx[4] = 1'b1;
      x      = x >> 16;
    end
    if (x[7:0] == '0) begin
      idx[3] = 1'b1;
      x      = x >> 8;
    end
    if (x[3:0] == '0) begin
      idx[2] = 1'b1;
      x      = x >> 4;
    end
    if (x[1:0] == '0) begin
      idx[1] = 1'b1;
      x      = x >> 2;
    end
    if (x[0] == 1'b0) begin
      idx[0] = 1'b1;
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bitmap_frame_allocator_unit.sv =====
// Bitmap page-frame allocator: next-fit search over a one-bit-per-frame used map.
// Free and mark-used read and update a single map word; allocate reads 32-frame map
// words in turn (at most 129 words scanned); rejected requests skip the map read.
// One request at a time; ready again in the same cycle the response turns valid, and
// a response not yet taken holds the next one in its output state.
// Reset: map reads as all used via per-word valid flags, hint/count 0, limit 4096.
`timescale 1ns / 1ps

module bitmap_frame_allocator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bfa_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  bfa_pkg::bfa_req_t          req_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output bfa_pkg::bfa_rsp_t          rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [bfa_pkg::CNT_W-1:0]     limit_q, hint_q, hint_d, count_q, count_d;
  logic [bfa_pkg::CNT_W-1:0]     lo_q, lo_d, hi_q, hi_d, wrap_q, wrap_d;
  logic                          phase_b_q, phase_b_d;
  logic [bfa_pkg::WORD_AW-1:0]   ptr_q, ptr_d;
  logic [1:0]                    act_q;
  logic [bfa_pkg::FRAME_W-1:0]   frame_q;
  logic [bfa_pkg::FRAME_W-1:0]   gnt_q, gnt_d;
  logic [1:0]                    stat_q, stat_d;
  logic [bfa_pkg::WORDS-1:0]     row_valid_q;
  logic                          rsp_valid_q;
  bfa_pkg::bfa_rsp_t             rsp_q;

  logic [bfa_pkg::CNT_W-1:0]     lim, wrap_end, hi_m1;
  logic [bfa_pkg::WORD_W-1:0]    ram_rdata, word, lo_mask, hi_mask, cand, wr_word;
  logic                          last_word, found;
  logic [bfa_pkg::BIT_W-1:0]     hit_bit;
  logic [bfa_pkg::FRAME_W-1:0]   hit_pos;
  logic                          ram_we, cur_bit, want_used;
  logic                          accept;

  assign accept      = req_valid_i && req_ready_o;
  assign req_ready_o = (state_q == S_IDLE);

  assign lim      = (limit_q < bfa_pkg::FRAMES_CNT) ? limit_q : bfa_pkg::FRAMES_CNT;
  assign wrap_end = (hint_q < lim) ? hint_q : lim;

  bfa_ram #(
    .W     (bfa_pkg::WORD_W),
    .DEPTH (bfa_pkg::WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (wr_word),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign word = row_valid_q[ptr_q] ? ram_rdata : '1;

  assign hi_m1     = hi_q - bfa_pkg::CNT_W'(1);
  assign last_word = ({1'b0, ptr_q} == hi_m1[bfa_pkg::CNT_W-1:bfa_pkg::BIT_W]);
  assign lo_mask   = (ptr_q == lo_q[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W])
                   ? ({bfa_pkg::WORD_W{1'b1}} << lo_q[bfa_pkg::BIT_W-1:0])
                   : '1;
  assign hi_mask   = (last_word && (hi_q[bfa_pkg::BIT_W-1:0] != '0))
                   ? ((bfa_pkg::WORD_W'(1) << hi_q[bfa_pkg::BIT_W-1:0])
                      - bfa_pkg::WORD_W'(1))
                   : '1;
  assign cand      = ~word & lo_mask & hi_mask;
  assign found     = (cand != '0);
  assign hit_bit   = bfa_pkg::first_one(cand);
  assign hit_pos   = {ptr_q, hit_bit};

  assign want_used = (act_q == bfa_pkg::ACT_MARK);
  assign cur_bit   = word[frame_q[bfa_pkg::BIT_W-1:0]];

  always_comb begin
    wr_word = word;
    if (act_q == bfa_pkg::ACT_ALLOC) begin
      wr_word[hit_bit] = 1'b1;
    end else begin
      wr_word[frame_q[bfa_pkg::BIT_W-1:0]] = want_used;
    end
  end

  always_comb begin
    state_d   = state_q;
    hint_d    = hint_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    wrap_d    = wrap_q;
    phase_b_d = phase_b_q;
    ptr_d     = ptr_q;
    gnt_d     = gnt_q;
    stat_d    = stat_q;
    ram_we    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          gnt_d  = req_i.frame;
          stat_d = bfa_pkg::ST_DONE;
          wrap_d = wrap_end;
          if (req_i.action == bfa_pkg::ACT_ALLOC) begin
            if (hint_q < lim) begin
              phase_b_d = 1'b0;
              lo_d      = hint_q;
              hi_d      = lim;
              ptr_d     = hint_q[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
              state_d   = S_RD;
            end else if (wrap_end != '0) begin
              phase_b_d = 1'b1;
              lo_d      = '0;
              hi_d      = wrap_end;
              ptr_d     = '0;
              state_d   = S_RD;
            end else begin
              stat_d  = bfa_pkg::ST_NO_FREE;
              state_d = S_OUT;
            end
          end else if ((req_i.action == bfa_pkg::ACT_FREE ||
                        req_i.action == bfa_pkg::ACT_MARK) &&
                       ({1'b0, req_i.frame} < bfa_pkg::FRAMES_CNT)) begin
            ptr_d   = req_i.frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
            state_d = S_RD;
          end else begin
            stat_d  = bfa_pkg::ST_RANGE;
            state_d = S_OUT;
          end
        end
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        if (act_q == bfa_pkg::ACT_ALLOC) begin
          if (found) begin
            ram_we  = 1'b1;
            gnt_d   = hit_pos;
            hint_d  = {1'b0, hit_pos} + bfa_pkg::CNT_W'(1);
            count_d = count_q - bfa_pkg::CNT_W'(1);
            state_d = S_OUT;
          end else if (!last_word) begin
            ptr_d   = ptr_q + bfa_pkg::WORD_AW'(1);
            state_d = S_RD;
          end else if (!phase_b_q && (wrap_q != '0)) begin
            phase_b_d = 1'b1;
            lo_d      = '0;
            hi_d      = wrap_q;
            ptr_d     = '0;
            state_d   = S_RD;
          end else begin
            stat_d  = bfa_pkg::ST_NO_FREE;
            state_d = S_OUT;
          end
        end else begin
          if (cur_bit == want_used) begin
            stat_d = bfa_pkg::ST_SAME;
          end else begin
            ram_we  = 1'b1;
            count_d = want_used ? (count_q - bfa_pkg::CNT_W'(1))
                                : (count_q + bfa_pkg::CNT_W'(1));
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= bfa_pkg::FRAMES_CNT;
      hint_q      <= '0;
      count_q     <= '0;
      row_valid_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        row_valid_q[ptr_q] <= 1'b1;
      end
      if (state_q == S_OUT && (!rsp_valid_q || rsp_ready_i)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    wrap_q    <= wrap_d;
    phase_b_q <= phase_b_d;
    ptr_q     <= ptr_d;
    gnt_q     <= gnt_d;
    stat_q    <= stat_d;
    if (accept) begin
      act_q   <= req_i.action;
      frame_q <= req_i.frame;
    end
    if (state_q == S_OUT && (!rsp_valid_q || rsp_ready_i)) begin
      rsp_q.granted_frame <= gnt_q;
      rsp_q.status        <= stat_q;
      rsp_q.free_cnt      <= count_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int unsigned W     = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/tb_bitmap_frame_allocator_unit.sv =====
// Testbench for the bitmap frame allocator: predicted responses checked against the block.
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator_unit;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [bfa_pkg::CNT_W-1:0] cfg_wdata_i = '0;
  logic                      req_valid_i = 1'b0;
  logic                      req_ready_o;
  bfa_pkg::bfa_req_t         req_i       = '0;
  logic                      rsp_valid_o;
  logic                      rsp_ready_i = 1'b0;
  bfa_pkg::bfa_rsp_t         rsp_o;

  bitmap_frame_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted allocator state
  logic [bfa_pkg::FRAMES-1:0] used_map_m = '1;
  logic [bfa_pkg::CNT_W-1:0]  hint_m     = '0;
  logic [bfa_pkg::CNT_W-1:0]  free_m     = '0;
  logic [bfa_pkg::CNT_W-1:0]  limit_m    = bfa_pkg::FRAMES_CNT;

  bfa_pkg::bfa_rsp_t predicted_rsp_q[$];
  bit          no_idle      = 1'b0;
  bit          hold_pending = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_sent       = 0;
  int unsigned n_checked    = 0;
  int unsigned n_errors     = 0;
  int unsigned n_status[4]  = '{0, 0, 0, 0};

  function automatic bfa_pkg::bfa_rsp_t predict_frame_op(input bfa_pkg::bfa_req_t r);
    bfa_pkg::bfa_rsp_t rsp;
    int unsigned lim;
    int unsigned wrap_end;
    int unsigned lo;
    int unsigned hi;
    int unsigned i;
    bit          found;
    bit          want_used;
    rsp.granted_frame = r.frame;
    rsp.status        = bfa_pkg::ST_DONE;
    case (r.action)
      bfa_pkg::ACT_ALLOC: begin
        lim      = (int'(limit_m) < bfa_pkg::FRAMES) ? int'(limit_m) : bfa_pkg::FRAMES;
        wrap_end = (int'(hint_m) < lim) ? int'(hint_m) : lim;
        found    = 1'b0;
        for (int pass = 0; pass < 2 && !found; pass++) begin
          lo = (pass == 0) ? int'(hint_m) : 0;
          hi = (pass == 0) ? lim : wrap_end;
          for (i = lo; i < hi && !found; i++) begin
            if (!used_map_m[i]) begin
              used_map_m[i]     = 1'b1;
              free_m            = free_m - 1'b1;
              hint_m            = bfa_pkg::CNT_W'(i + 1);
              rsp.granted_frame = bfa_pkg::FRAME_W'(i);
              found             = 1'b1;
            end
          end
        end
        if (!found) rsp.status = bfa_pkg::ST_NO_FREE;
      end
      bfa_pkg::ACT_FREE, bfa_pkg::ACT_MARK: begin
        want_used = (r.action == bfa_pkg::ACT_MARK);
        if (int'(r.frame) >= bfa_pkg::FRAMES) begin
          rsp.status = bfa_pkg::ST_RANGE;
        end else if (used_map_m[r.frame] == want_used) begin
          rsp.status = bfa_pkg::ST_SAME;
        end else begin
          used_map_m[r.frame] = want_used;
          free_m = want_used ? free_m - 1'b1 : free_m + 1'b1;
        end
      end
      default: rsp.status = bfa_pkg::ST_RANGE;
    endcase
    rsp.free_cnt = free_m;
    return rsp;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      n_errors++;
    end
  endtask

  task automatic check_response(input bfa_pkg::bfa_rsp_t got);
    bfa_pkg::bfa_rsp_t want;
    if (predicted_rsp_q.size() == 0) begin
      $display("%0t: unexpected response: expected none, got frame %0d status %0d free %0d",
               $time, got.granted_frame, got.status, got.free_cnt);
      n_errors++;
    end else begin
      want = predicted_rsp_q.pop_front();
      check_field("granted_frame", want.granted_frame, got.granted_frame);
      check_field("status", want.status, got.status);
      check_field("free_cnt", want.free_cnt, got.free_cnt);
      n_checked++;
      n_status[want.status]++;
    end
  endtask

  // response side: checks, random stalls, and long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) check_response(rsp_o);
      if (hold_pending) begin
        hold_left    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= no_idle || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      stall_cycles = 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  task automatic issue_request(input bfa_pkg::bfa_req_t r);
    while (!no_idle && $urandom_range(99) < 16) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_i       <= r;
    req_valid_i <= 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
    predicted_rsp_q.push_back(predict_frame_op(r));
    n_sent++;
  endtask

  task automatic issue_op(input logic [1:0] act,
                          input logic [bfa_pkg::FRAME_W-1:0] frame);
    bfa_pkg::bfa_req_t r;
    r.action = act;
    r.frame  = frame;
    issue_request(r);
  endtask

  task automatic wait_drained();
    req_valid_i <= 1'b0;
    while (predicted_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_limit(input logic [bfa_pkg::CNT_W-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_m = value;
  endtask

  function automatic logic [bfa_pkg::FRAME_W-1:0] pick_frame(input int unsigned base,
                                                             input int unsigned span);
    int unsigned p;
    p = $urandom_range(99);
    if (p < 75) return bfa_pkg::FRAME_W'(base + $urandom_range(span - 1));
    if (p < 83) return bfa_pkg::FRAME_W'($urandom_range(3));
    if (p < 90) return bfa_pkg::FRAME_W'(bfa_pkg::FRAMES - 1 - $urandom_range(3));
    return bfa_pkg::FRAME_W'($urandom);
  endfunction

  // frees part of a window first so allocations succeed, then mixed traffic
  task automatic run_random_mix(input logic [bfa_pkg::CNT_W-1:0] limit,
                                input int unsigned base, input int unsigned span,
                                input int unsigned count);
    int unsigned p;
    logic [1:0]  act;
    write_frame_limit(limit);
    for (int i = 0; i < span / 2; i++) begin
      issue_op(bfa_pkg::ACT_FREE, bfa_pkg::FRAME_W'(base + $urandom_range(span - 1)));
    end
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (p < 38)      act = bfa_pkg::ACT_ALLOC;
      else if (p < 72) act = bfa_pkg::ACT_FREE;
      else if (p < 96) act = bfa_pkg::ACT_MARK;
      else             act = ACT_UNUSED;
      issue_op(act, pick_frame(base, span));
    end
  endtask

  task automatic test_directed();
    issue_op(bfa_pkg::ACT_ALLOC, 12'hABC);
    issue_op(bfa_pkg::ACT_MARK, 12'd0);
    issue_op(bfa_pkg::ACT_FREE, 12'd0);
    issue_op(bfa_pkg::ACT_FREE, 12'd0);
    issue_op(bfa_pkg::ACT_FREE, 12'hFFF);
    issue_op(ACT_UNUSED, 12'hFFF);
    issue_op(ACT_UNUSED, 12'd0);
    issue_op(bfa_pkg::ACT_ALLOC, 12'h555);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    issue_op(bfa_pkg::ACT_FREE, 12'd100);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    issue_op(bfa_pkg::ACT_FREE, 12'd31);
    issue_op(bfa_pkg::ACT_FREE, 12'd32);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    issue_op(bfa_pkg::ACT_FREE, 12'd2048);
    issue_op(bfa_pkg::ACT_MARK, 12'd2048);
    issue_op(bfa_pkg::ACT_MARK, 12'd2048);
    issue_op(bfa_pkg::ACT_FREE, 12'd10);
    issue_op(bfa_pkg::ACT_FREE, 12'd4000);
    // hint now sits past a small limit
    write_frame_limit(13'd8);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    issue_op(bfa_pkg::ACT_FREE, 12'd7);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    write_frame_limit(13'h1FFF);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
    issue_op(bfa_pkg::ACT_ALLOC, 12'd0);
  endtask

  task automatic test_full_map();
    run_random_mix(bfa_pkg::FRAMES_CNT, $urandom_range(0, bfa_pkg::FRAMES - 64), 64, 280);
  endtask

  task automatic test_top_of_map();
    run_random_mix(bfa_pkg::FRAMES_CNT - 1'b1, bfa_pkg::FRAMES - 64, 64, 80);
  endtask

  task automatic test_small_limit();
    run_random_mix(bfa_pkg::CNT_W'($urandom_range(1, 40)), 0, 64, 220);
  endtask

  task automatic test_limit_above_map();
    no_idle = 1'b1;
    run_random_mix(13'h1FFF, $urandom_range(0, bfa_pkg::FRAMES - 64), 64, 220);
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_zero_limit();
    run_random_mix(13'd0, $urandom_range(0, bfa_pkg::FRAMES - 16), 16, 16);
  endtask

  task automatic test_backpressure();
    write_frame_limit(bfa_pkg::FRAMES_CNT);
    hold_pending = 1'b1;
    for (int i = 0; i < 12; i++) begin
      issue_op(($urandom_range(1) != 0) ? bfa_pkg::ACT_ALLOC : bfa_pkg::ACT_FREE,
               pick_frame(0, 64));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_map();
    test_top_of_map();
    test_small_limit();
    test_limit_above_map();
    test_backpressure();
    test_zero_limit();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests over frame limits 0, small, 4095, 4096 and 8191.",
             n_sent);
    $display("Checked %0d responses: %0d done, %0d no free, %0d unchanged, %0d range.",
             n_checked, n_status[bfa_pkg::ST_DONE], n_status[bfa_pkg::ST_NO_FREE],
             n_status[bfa_pkg::ST_SAME], n_status[bfa_pkg::ST_RANGE]);
    if (n_errors == 0 && predicted_rsp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
